// ----- sv/ffba_pkg.sv -----
`timescale 1ns / 1ps
package ffba_pkg;
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int ADDR_BITS_DEF    = 48;
    localparam int FIELD_BITS       = 48;

    localparam logic [1:0] FUNC_APPEND = 2'd0;
    localparam logic [1:0] FUNC_ALLOC  = 2'd1;
    localparam logic [1:0] FUNC_FREE   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOMEM    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]            func;
        logic [FIELD_BITS-1:0] addr_in;
        logic [FIELD_BITS-1:0] size_in;
    } t_req;

    typedef struct packed {
        logic [1:0]            status;
        logic [FIELD_BITS-1:0] addr_out;
        logic [FIELD_BITS-1:0] total_bytes;
        logic [FIELD_BITS-1:0] free_bytes;
    } t_rsp;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,      // capture request, start at list head
        OP_APPEND,     // write a new descriptor at the free slot
        OP_SRCH_RD,    // read descriptor at cursor
        OP_SRCH_EVAL,  // evaluate read descriptor, update or advance
        OP_COAL_START, // clear dirty, cursor to head
        OP_COAL_RD,
        OP_COAL_RDN,
        OP_COAL_EVAL,
        OP_FREE_RD,
        OP_FREE_EVAL,
        OP_SUM_START,
        OP_SUM_RD,
        OP_SUM_EVAL,
        OP_FINISH
    } t_op;

    typedef struct packed {
        logic cur_nil;   // cursor at null index
        logic nxt_nil;   // next link null
        logic hit;       // evaluated descriptor matched
        logic fail_full; // split needed but no slot
        logic slot_ok;   // a free slot exists
        logic undersize; // append region smaller than header
        logic dirty;
        logic merge;     // coalesce condition true
    } t_sts;
endpackage

// ----- sv/ffba_ctrl.sv -----
`timescale 1ns / 1ps
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_func,
    output logic       o_busy,
    input  logic       i_out_free,
    input  t_sts       i_sts,
    output t_op        o_op,
    output logic       o_retry
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DISP  = 11'b00000000010,
        S_SRD   = 11'b00000000100,
        S_SEV   = 11'b00000001000,
        S_CST   = 11'b00000010000,
        S_CRD   = 11'b00000100000,
        S_CRN   = 11'b00001000000,
        S_CEV   = 11'b00010000000,
        S_FRD   = 11'b00100000000,
        S_SUM   = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_retry, n_retry;
    logic   r_sumev, n_sumev;
    logic   r_frev, n_frev;
    logic   r_sumst, n_sumst;

    assign o_busy  = (r_state != S_IDLE);
    assign o_retry = r_retry;

    always_comb begin
        n_state = r_state;
        n_retry = r_retry;
        n_sumev = r_sumev;
        n_frev  = r_frev;
        n_sumst = r_sumst;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_op    = OP_LATCH;
                    n_retry = 1'b0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_func)
                    FUNC_APPEND: begin
                        o_op = OP_APPEND;
                        n_sumst = 1'b1;
                        n_state = S_SUM;
                    end
                    FUNC_ALLOC: n_state = S_SRD;
                    FUNC_FREE: begin
                        n_frev = 1'b0;
                        n_state = S_FRD;
                    end
                    default: begin
                        n_sumst = 1'b1;
                        n_state = S_SUM;
                    end
                endcase
            end
            S_SRD: begin
                if (i_sts.cur_nil) begin
                    if (i_sts.dirty && !r_retry) begin
                        n_state = S_CST;
                    end else begin
                        n_sumst = 1'b1;
                        n_state = S_SUM;
                    end
                end else begin
                    o_op = OP_SRCH_RD;
                    n_state = S_SEV;
                end
            end
            S_SEV: begin
                o_op = OP_SRCH_EVAL;
                if (i_sts.hit || i_sts.fail_full) begin
                    n_sumst = 1'b1;
                    n_state = S_SUM;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_CST: begin
                o_op = OP_COAL_START;
                n_retry = 1'b1;
                n_state = S_CRD;
            end
            S_CRD: begin
                if (i_sts.cur_nil) begin
                    // Rewind the cursor so the second search starts at the head.
                    o_op = OP_COAL_START;
                    n_state = S_SRD;
                end else begin
                    o_op = OP_COAL_RD;
                    n_state = S_CRN;
                end
            end
            S_CRN: begin
                if (i_sts.nxt_nil) begin
                    o_op = OP_COAL_START;
                    n_state = S_SRD;
                end else begin
                    o_op = OP_COAL_RDN;
                    n_state = S_CEV;
                end
            end
            S_CEV: begin
                o_op = OP_COAL_EVAL;
                n_state = S_CRD;
            end
            S_FRD: begin
                if (!r_frev) begin
                    if (i_sts.cur_nil) begin
                        n_sumst = 1'b1;
                        n_state = S_SUM;
                    end else begin
                        o_op = OP_FREE_RD;
                        n_frev = 1'b1;
                    end
                end else begin
                    o_op = OP_FREE_EVAL;
                    n_frev = 1'b0;
                    if (i_sts.hit) begin
                        n_sumst = 1'b1;
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                if (r_sumst) begin
                    o_op = OP_SUM_START;
                    n_sumst = 1'b0;
                    n_sumev = 1'b0;
                end else if (!r_sumev) begin
                    if (i_sts.cur_nil) begin
                        n_state = S_FIN;
                    end else begin
                        o_op = OP_SUM_RD;
                        n_sumev = 1'b1;
                    end
                end else begin
                    o_op = OP_SUM_EVAL;
                    n_sumev = 1'b0;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_op = OP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_retry <= 1'b0;
            r_sumev <= 1'b0;
            r_frev  <= 1'b0;
            r_sumst <= 1'b0;
        end else begin
            r_state <= n_state;
            r_retry <= n_retry;
            r_sumev <= n_sumev;
            r_frev  <= n_frev;
            r_sumst <= n_sumst;
        end
    end
endmodule

// ----- sv/ffba_dp.sv -----
`timescale 1ns / 1ps
module ffba_dp
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_op  i_op,
    input  logic i_retry,
    input  t_req i_req,
    output t_sts o_sts,
    output t_rsp o_rsp
);
    localparam int IW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = $clog2(MAX_BLOCKS);
    localparam int FW = FIELD_BITS;
    localparam logic [IW-1:0] NIL = IW'(MAX_BLOCKS);
    localparam logic [ADDR_BITS-1:0] HDR = ADDR_BITS'(HEADER_BYTES);
    localparam logic [FW-1:0] FMAX = {FW{1'b1}};

    // Descriptor memories: base, size and link per slot.
    logic [ADDR_BITS-1:0] m_base [MAX_BLOCKS];
    logic [ADDR_BITS-1:0] m_size [MAX_BLOCKS];
    logic [IW-1:0]        m_link [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_used, r_valid;
    logic [IW-1:0] r_head, r_tail, r_cur;
    logic r_dirty;

    logic [ADDR_BITS-1:0] r_rbase, r_rsize, r_nbase, r_nsize;
    logic [IW-1:0]        r_rlink, r_nlink;
    logic [ADDR_BITS-1:0] r_addr, r_size;
    logic [1:0]           r_status;
    logic [FW-1:0]        r_pay, r_total, r_free;
    logic                 r_hit;

    // First free slot: priority encode over valid bits.
    logic [SW-1:0] slot;
    logic          slot_ok;
    always_comb begin
        slot = '0;
        slot_ok = 1'b0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                slot = SW'(i);
                slot_ok = 1'b1;
            end
        end
    end

    logic [SW-1:0] cur_s;
    logic [SW-1:0] nx_s;
    assign cur_s = r_cur[SW-1:0];
    assign nx_s  = r_rlink[SW-1:0];

    logic cur_used, nx_used;
    assign cur_used = r_used[cur_s];
    assign nx_used  = r_used[nx_s];

    logic [ADDR_BITS-1:0] rem;
    logic exact, split, merge;
    assign rem   = r_rsize - r_size;
    assign exact = !cur_used && (r_rsize == r_size);
    assign split = !cur_used && (r_rsize > r_size) && (rem > HDR);
    assign merge = !cur_used && !nx_used && ((r_rbase + r_rsize + HDR) == r_nbase);

    logic [ADDR_BITS-1:0] pay_a;
    assign pay_a = r_rbase + HDR;

    // Saturating accumulate in a wider word.
    logic [FW:0] blk, tsum, fsum;
    logic [FW-1:0] blk_s;
    assign blk   = {1'b0, FW'(r_rsize)} + (FW+1)'(HEADER_BYTES);
    assign blk_s = blk[FW] ? FMAX : blk[FW-1:0];
    assign tsum  = {1'b0, r_total} + {1'b0, blk_s};
    assign fsum  = {1'b0, r_free} + {1'b0, FW'(r_rsize)};

    always_comb begin
        o_sts.cur_nil   = (r_cur >= NIL);
        o_sts.nxt_nil   = (r_rlink >= NIL);
        o_sts.hit       = (i_op == OP_SRCH_EVAL) ? (exact || (split && slot_ok))
                          : ((pay_a == r_addr) && !r_hit);
        o_sts.fail_full = !exact && split && !slot_ok;
        o_sts.slot_ok   = slot_ok;
        o_sts.undersize = (r_size < HDR);
        o_sts.dirty     = r_dirty;
        o_sts.merge     = merge;
        o_rsp.status      = r_status;
        o_rsp.addr_out    = r_pay;
        o_rsp.total_bytes = r_total;
        o_rsp.free_bytes  = r_free;
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_SRCH_RD, OP_COAL_RD, OP_FREE_RD, OP_SUM_RD: begin
                r_rbase <= m_base[cur_s];
                r_rsize <= m_size[cur_s];
                r_rlink <= m_link[cur_s];
            end
            OP_COAL_RDN: begin
                r_nbase <= m_base[nx_s];
                r_nsize <= m_size[nx_s];
                r_nlink <= m_link[nx_s];
            end
            default: ;
        endcase
        case (i_op)
            OP_APPEND: begin
                if (!(r_size < HDR) && slot_ok) begin
                    m_base[slot] <= r_addr;
                    m_size[slot] <= r_size - HDR;
                    m_link[slot] <= NIL;
                    if (r_head < NIL) m_link[r_tail[SW-1:0]] <= IW'(slot);
                end
            end
            OP_SRCH_EVAL: begin
                if (!exact && split && slot_ok) begin
                    m_base[slot] <= r_rbase + r_size + HDR;
                    m_size[slot] <= rem - HDR;
                    m_link[slot] <= r_rlink;
                    m_link[cur_s] <= IW'(slot);
                    m_size[cur_s] <= r_size;
                end
            end
            OP_COAL_EVAL: begin
                if (merge) begin
                    m_size[cur_s] <= r_rsize + r_nsize + HDR;
                    m_link[cur_s] <= r_nlink;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_valid <= '0;
            r_head  <= NIL;
            r_tail  <= NIL;
            r_dirty <= 1'b0;
            r_cur   <= NIL;
            r_hit   <= 1'b0;
        end else begin
            case (i_op)
                OP_LATCH: begin
                    r_addr   <= ADDR_BITS'(i_req.addr_in);
                    r_size   <= ADDR_BITS'(i_req.size_in);
                    r_status <= ST_OK;
                    r_pay    <= '0;
                    r_hit    <= 1'b0;
                    r_cur    <= r_head;
                    if (i_req.func == FUNC_ALLOC) r_status <= ST_NOMEM;
                    if (i_req.func == FUNC_FREE) r_status <= ST_NOTFOUND;
                end
                OP_APPEND: begin
                    if (r_size < HDR) begin
                        r_status <= ST_NOMEM;
                    end else if (!slot_ok) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_valid[slot] <= 1'b1;
                        r_used[slot]  <= 1'b0;
                        if (r_head >= NIL) r_head <= IW'(slot);
                        r_tail  <= IW'(slot);
                        r_dirty <= 1'b1;
                    end
                end
                OP_SRCH_EVAL: begin
                    if (exact) begin
                        r_used[cur_s] <= 1'b1;
                        r_dirty  <= 1'b1;
                        r_pay    <= FW'(pay_a);
                        r_status <= ST_OK;
                    end else if (split) begin
                        if (slot_ok) begin
                            r_valid[slot] <= 1'b1;
                            r_used[slot]  <= 1'b0;
                            r_used[cur_s] <= 1'b1;
                            if (r_tail == r_cur) r_tail <= IW'(slot);
                            r_dirty  <= 1'b1;
                            r_pay    <= FW'(pay_a);
                            r_status <= ST_OK;
                        end else begin
                            r_status <= ST_FULL;
                        end
                    end else begin
                        r_cur <= r_rlink;
                    end
                end
                OP_COAL_START: begin
                    r_dirty <= 1'b0;
                    r_cur   <= r_head;
                end
                OP_COAL_EVAL: begin
                    if (merge) begin
                        r_valid[nx_s] <= 1'b0;
                        if (r_tail == r_rlink) r_tail <= r_cur;
                    end else begin
                        r_cur <= r_rlink;
                    end
                end
                OP_FREE_EVAL: begin
                    if (pay_a == r_addr) begin
                        r_used[cur_s] <= 1'b0;
                        r_dirty  <= 1'b1;
                        r_status <= ST_OK;
                        r_hit    <= 1'b1;
                    end else begin
                        r_cur <= r_rlink;
                    end
                end
                OP_SUM_START: begin
                    r_cur   <= r_head;
                    r_total <= '0;
                    r_free  <= '0;
                end
                OP_SUM_EVAL: begin
                    r_total <= tsum[FW] ? FMAX : tsum[FW-1:0];
                    if (!cur_used) r_free <= fsum[FW] ? FMAX : fsum[FW-1:0];
                    r_cur <= r_rlink;
                end
                default: ;
            endcase
            if (i_op == OP_SRCH_RD && i_retry && r_status == ST_FULL) r_hit <= 1'b1;
        end
    end
endmodule

// ----- sv/first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Signals                      Payload
// request   in   i_valid / o_stall            t_req  (func, addr_in, size_in)
// result    out  o_valid / i_stall            t_rsp  (status, addr_out, totals)
//
// One request at a time. A request takes a read and an evaluate step per descriptor
// walked in the first-fit or free search, a read, a next read and an evaluate step
// per descriptor in a coalesce pass, and a read and an evaluate step per descriptor
// in the closing byte count walk, as the descriptor memory is read one entry at a
// time; capture and dispatch come before the walks, and finish after them.
// Synchronous active-low reset empties the list; no clearing pass is needed.
// A held result in the output register stalls only the finish step.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);
    t_op  op;
    t_sts sts;
    t_rsp rsp;
    t_req r_req;
    logic busy, retry;
    logic r_oval;
    t_rsp r_orsp;

    // The request register holds the func code for the controller.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) r_req <= i_req;
    end

    assign o_stall = busy;
    assign o_valid = r_oval;
    assign o_rsp   = r_orsp;

    ffba_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_func(r_req.func), .o_busy(busy),
        .i_out_free(!r_oval || !i_stall),
        .i_sts(sts), .o_op(op), .o_retry(retry)
    );

    ffba_dp #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES),
              .ADDR_BITS(ADDR_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op), .i_retry(retry),
        .i_req(i_req), .o_sts(sts), .o_rsp(rsp)
    );

    // Output register: loaded at finish, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (op == OP_FINISH) begin
            r_oval <= 1'b1;
        end else if (!i_stall) begin
            r_oval <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (op == OP_FINISH) r_orsp <= rsp;
    end
endmodule

// ----- sv/ffba_checker.sv -----
`timescale 1ns / 1ps
module ffba_checker
    import ffba_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_rsp o_rsp
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted request did not make block busy");
    a_free_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.free_bytes <= o_rsp.total_bytes)
        else $error("free bytes exceed total");
    a_addr0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status != ST_OK |-> o_rsp.addr_out == '0)
        else $error("address on failure");
endmodule

bind first_fit_block_allocator ffba_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
);
